>>> design/rtc_pkg.sv
// shared widths, reset values, register codes and lookup tables of the rotary tuning controller
package rtc_pkg;

	localparam int CW         = 16;
	localparam int FREQ_W     = 27;
	localparam int BFO_W      = 28;
	localparam int WIN_W      = 15;
	localparam int STEP_W     = 17;
	localparam int VFO_W      = 30;
	localparam int OFS_W      = 4;
	localparam int IDX_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 28;

	// deltas that pass the window never exceed either of these widths
	localparam int AMW    = (CW < WIN_W) ? CW : WIN_W;
	localparam int CMP_W  = (CW > WIN_W) ? CW : WIN_W;
	localparam int PROD_W = STEP_W + AMW;
	localparam int SUM_W  = ((PROD_W > FREQ_W) ? PROD_W : FREQ_W) + 2;
	localparam int MOD_W  = 16;
	localparam int NUM_STEPS = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_BFO    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPLIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 3'd4;

	localparam logic [BFO_W-1:0]  BFO_RESET    = 28'd12000000;
	localparam logic [FREQ_W-1:0] LOW_RESET    = 27'd7000000;
	localparam logic [FREQ_W-1:0] HIGH_RESET   = 27'd7200000;
	localparam logic [FREQ_W-1:0] SPLIT_RESET  = 27'd10000000;
	localparam logic [WIN_W-1:0]  WINDOW_RESET = 15'd10;
	localparam logic [FREQ_W-1:0] FREQ_RESET   = 27'd7115000;
	localparam logic [IDX_W-1:0]  IDX_RESET    = 3'd2;

	typedef struct packed {
		logic [BFO_W-1:0]  bfo_frequency;
		logic [FREQ_W-1:0] band_low;
		logic [FREQ_W-1:0] band_high;
		logic [FREQ_W-1:0] sideband_split;
		logic [WIN_W-1:0]  delta_window;
	} rtc_cfg_t;

	typedef struct packed {
		logic signed [CW-1:0] last_position;
		logic [FREQ_W-1:0]    tuned_frequency;
		logic [IDX_W-1:0]     step_index;
		logic                 tuning_mode;
	} rtc_state_t;

	function automatic logic [STEP_W-1:0] step_of(input logic [IDX_W-1:0] idx);
		logic [STEP_W-1:0] s;
		case (idx)
			3'd0:    s = 17'd10;
			3'd1:    s = 17'd100;
			3'd2:    s = 17'd1000;
			3'd3:    s = 17'd10000;
			3'd4:    s = 17'd100000;
			default: s = 17'd10;
		endcase
		return s;
	endfunction

	function automatic logic [OFS_W-1:0] offset_of(input logic [IDX_W-1:0] idx);
		logic [OFS_W-1:0] o;
		case (idx)
			3'd0:    o = 4'd8;
			3'd1:    o = 4'd7;
			3'd2:    o = 4'd5;
			3'd3:    o = 4'd4;
			3'd4:    o = 4'd3;
			default: o = 4'd8;
		endcase
		return o;
	endfunction

endpackage

>>> design/rtc_knob_if.sv
// encoder poll channel: raw counter and mode button
interface rtc_knob_if;
	import rtc_pkg::*;

	logic          valid;
	logic          ready;
	logic [CW-1:0] counter_raw;
	logic          mode_button;

	modport source (output valid, output counter_raw, output mode_button, input ready);
	modport sink (input valid, input counter_raw, input mode_button, output ready);
endinterface

>>> design/rtc_report_if.sv
// result channel: frequency, oscillator, step and mode report
interface rtc_report_if;
	import rtc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [FREQ_W-1:0]       tuned_frequency_out;
	logic signed [VFO_W-1:0] vfo_frequency;
	logic [STEP_W-1:0]       step_size;
	logic [OFS_W-1:0]        digit_offset;
	logic                    tuning_mode_out;
	logic                    applied;

	modport source (output valid, output tuned_frequency_out, output vfo_frequency,
		output step_size, output digit_offset, output tuning_mode_out, output applied,
		input ready);
	modport sink (input valid, input tuned_frequency_out, input vfo_frequency,
		input step_size, input digit_offset, input tuning_mode_out, input applied,
		output ready);
endinterface

>>> design/rtc_cfg_if.sv
// configuration write channel: register index and data
interface rtc_cfg_if;
	import rtc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/rtc_update.sv
// next-state logic for one poll: knob delta, window check, frequency clamp, step rotation
module rtc_update (
	input  logic signed [rtc_pkg::CW-1:0] pos,
	input  logic                          button,
	input  rtc_pkg::rtc_state_t           cur,
	input  rtc_pkg::rtc_cfg_t             cfg,
	output rtc_pkg::rtc_state_t           nxt,
	output logic                          applied
);
	import rtc_pkg::*;

	logic signed [CW:0]       delta;
	logic                     neg;
	logic [CW:0]              mag_full;
	logic [CW-1:0]            mag;
	logic [AMW-1:0]           mag_a;
	logic                     ok;
	logic [STEP_W-1:0]        step_val;
	logic [PROD_W-1:0]        prod;
	logic signed [SUM_W-1:0]  base;
	logic signed [SUM_W-1:0]  fsum;
	logic signed [SUM_W-1:0]  low_x;
	logic signed [SUM_W-1:0]  high_x;
	logic [FREQ_W-1:0]        f_new;
	logic [MOD_W-1:0]         m16;
	logic [5:0]               nib_sum;
	logic [4:0]               fold;
	logic [IDX_W-1:0]         m5;
	logic [IDX_W-1:0]         shift;
	logic [3:0]               idx_sum;
	logic [IDX_W-1:0]         idx_new;

	// values up to 18 only
	function automatic logic [IDX_W-1:0] mod5_small(input logic [4:0] v);
		logic [4:0] r;
		if (v >= 5'd15) begin
			r = v - 5'd15;
		end else if (v >= 5'd10) begin
			r = v - 5'd10;
		end else if (v >= 5'd5) begin
			r = v - 5'd5;
		end else begin
			r = v;
		end
		return r[IDX_W-1:0];
	endfunction

	assign delta    = {pos[CW-1], pos} - {cur.last_position[CW-1], cur.last_position};
	assign neg      = delta[CW];
	assign mag_full = neg ? -delta : delta;
	assign mag      = mag_full[CW-1:0];
	assign mag_a    = mag[AMW-1:0];
	assign ok       = (delta != '0) && (CMP_W'(mag) < CMP_W'(cfg.delta_window));
	assign applied  = ok;

	// frequency mode: move by step times delta, floor tested before ceiling
	assign step_val = step_of(cur.step_index);
	assign prod     = PROD_W'(step_val) * PROD_W'(mag_a);
	assign base     = signed'(SUM_W'(cur.tuned_frequency));
	assign fsum     = neg ? base - signed'(SUM_W'(prod)) : base + signed'(SUM_W'(prod));
	assign low_x    = signed'(SUM_W'(cfg.band_low));
	assign high_x   = signed'(SUM_W'(cfg.band_high));

	always_comb begin
		if (fsum < low_x) begin
			f_new = cfg.band_low;
		end else if (fsum > high_x) begin
			f_new = cfg.band_high;
		end else begin
			f_new = fsum[FREQ_W-1:0];
		end
	end

	// |delta| mod 5 by nibble folding, since 16 is 1 mod 5
	assign m16     = MOD_W'(mag_a);
	assign nib_sum = 6'(m16[3:0]) + 6'(m16[7:4]) + 6'(m16[11:8]) + 6'(m16[15:12]);
	assign fold    = 5'(nib_sum[5:4]) + 5'(nib_sum[3:0]);
	assign m5      = mod5_small(fold);

	// index moves by minus delta
	assign shift   = neg ? m5 : ((m5 == '0) ? '0 : 3'(NUM_STEPS) - m5);
	assign idx_sum = 4'(cur.step_index) + 4'(shift);
	assign idx_new = (idx_sum >= 4'(NUM_STEPS)) ? 3'(idx_sum - 4'(NUM_STEPS)) : idx_sum[IDX_W-1:0];

	always_comb begin
		nxt = cur;
		nxt.last_position = pos;
		if (ok && !cur.tuning_mode) begin
			nxt.tuned_frequency = f_new;
		end
		if (ok && cur.tuning_mode) begin
			nxt.step_index = idx_new;
		end
		nxt.tuning_mode = cur.tuning_mode ^ button;
	end

endmodule

>>> design/rotary_tuning_controller_core.sv
// top level of the rotary tuning controller: input stage, state update, result register
//
//  channel | dir | handshake     | payload
//  knob    | in  | valid / ready | counter_raw, mode_button
//  report  | out | valid / ready | tuned_frequency_out, vfo_frequency, step_size,
//          |     |               | digit_offset, tuning_mode_out, applied
//  cfg     | in  | valid / ready | index, data (ready is always high)
//
// three register stages: decoded knob position, state update, result register.
// one item per cycle unless the report channel stalls; the state loop (delta, step
// multiply, clamp) closes through the stage-2 state registers alone.
// each stage holds while the one after it is full and stalled, and fills any bubble.
// arst_n restores the register defaults and the power-up state and empties all stages.
module rotary_tuning_controller_core (
	input logic           clk,
	input logic           arst_n,
	rtc_knob_if.sink      knob,
	rtc_report_if.source  report,
	rtc_cfg_if.sink       cfg
);
	import rtc_pkg::*;

	function automatic logic signed [CW-1:0] knob_position(input logic [CW-1:0] raw);
		logic [CW-1:0] rm1;
		logic [CW-2:0] p;
		rm1 = raw - 1'b1;
		p   = ~rm1[CW-1:1];
		// above half of the half range the position wraps to negative
		return (p > (CW-1)'(1 << (CW-2))) ? {1'b1, p} : {1'b0, p};
	endfunction

	rtc_cfg_t   cfg_q;
	rtc_state_t state_q;
	rtc_state_t state_nxt;
	logic       applied_nxt;

	logic                    valid_s1;
	logic signed [CW-1:0]    pos_s1;
	logic                    button_s1;
	logic                    valid_s2;
	logic                    applied_s2;
	logic                    valid_s3;
	logic [FREQ_W-1:0]       freq_s3;
	logic signed [VFO_W-1:0] vfo_s3;
	logic [STEP_W-1:0]       step_s3;
	logic [OFS_W-1:0]        ofs_s3;
	logic                    mode_s3;
	logic                    applied_s3;

	logic rdy_s1;
	logic rdy_s2;
	logic rdy_s3;

	assign rdy_s3 = !valid_s3 || report.ready;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign rdy_s1 = !valid_s1 || rdy_s2;

	assign knob.ready = rdy_s1;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bfo_frequency  <= BFO_RESET;
			cfg_q.band_low       <= LOW_RESET;
			cfg_q.band_high      <= HIGH_RESET;
			cfg_q.sideband_split <= SPLIT_RESET;
			cfg_q.delta_window   <= WINDOW_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_BFO:    cfg_q.bfo_frequency  <= cfg.data[BFO_W-1:0];
				CFG_LOW:    cfg_q.band_low       <= cfg.data[FREQ_W-1:0];
				CFG_HIGH:   cfg_q.band_high      <= cfg.data[FREQ_W-1:0];
				CFG_SPLIT:  cfg_q.sideband_split <= cfg.data[FREQ_W-1:0];
				CFG_WINDOW: cfg_q.delta_window   <= cfg.data[WIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// stage 1: decoded knob position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= knob.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (knob.valid && rdy_s1) begin
			pos_s1    <= knob_position(knob.counter_raw);
			button_s1 <= knob.mode_button;
		end
	end

	rtc_update u_update (
		.pos     (pos_s1),
		.button  (button_s1),
		.cur     (state_q),
		.cfg     (cfg_q),
		.nxt     (state_nxt),
		.applied (applied_nxt)
	);

	// stage 2: state registers hold the item that sits in this stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2                <= 1'b0;
			applied_s2              <= 1'b0;
			state_q.last_position   <= '0;
			state_q.tuned_frequency <= FREQ_RESET;
			state_q.step_index      <= IDX_RESET;
			state_q.tuning_mode     <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q    <= state_nxt;
				applied_s2 <= applied_nxt;
			end
		end
	end

	// stage 3: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && rdy_s3) begin
			freq_s3    <= state_q.tuned_frequency;
			step_s3    <= step_of(state_q.step_index);
			ofs_s3     <= offset_of(state_q.step_index);
			mode_s3    <= state_q.tuning_mode;
			applied_s3 <= applied_s2;
			if (state_q.tuned_frequency < cfg_q.sideband_split) begin
				vfo_s3 <= signed'(VFO_W'(cfg_q.bfo_frequency))
					- signed'(VFO_W'(state_q.tuned_frequency));
			end else begin
				vfo_s3 <= signed'(VFO_W'(cfg_q.bfo_frequency))
					+ signed'(VFO_W'(state_q.tuned_frequency));
			end
		end
	end

	assign report.valid               = valid_s3;
	assign report.tuned_frequency_out = freq_s3;
	assign report.vfo_frequency       = vfo_s3;
	assign report.step_size           = step_s3;
	assign report.digit_offset        = ofs_s3;
	assign report.tuning_mode_out     = mode_s3;
	assign report.applied             = applied_s3;

	a_step_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.step_index <= 3'(NUM_STEPS - 1))
		else $error("step index out of range");

	a_state_holds_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !rdy_s3 |=> $stable(state_q))
		else $error("state changed while stage 2 was stalled");

	a_s1_fills_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		knob.valid && knob.ready |=> valid_s1)
		else $error("accepted item missing from stage 1");

	a_s3_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s3) |-> $past(valid_s2))
		else $error("result appeared without an item in stage 2");

endmodule
